>>> rtl/sje_pkg.sv
// ----------------------------------------------------------------------------
// sje_pkg: shared constants for the sonar height filter
// Field widths, register reset values and register indexes.
// ----------------------------------------------------------------------------
package sje_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int COUNT_PORT_WIDTH    = 32;
   localparam int MUL_WIDTH           = 32;
   localparam int PROD_WIDTH          = 2 * MUL_WIDTH;
   localparam int HEIGHT_WIDTH        = 24;
   localparam int AVG_WIDTH           = 32;
   localparam int ALPHA_WIDTH         = 16;
   localparam int ALPHA_SHIFT         = 15;
   localparam int RUN_WIDTH           = 4;
   localparam int CSR_INDEX_WIDTH     = 4;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam logic [HEIGHT_WIDTH-1:0] HEIGHT_MAX = '1;
   localparam logic [ALPHA_WIDTH-1:0]  ALPHA_ONE  = 16'h8000;

   localparam logic [31:0]           COUNT_GAIN_RESET  = 32'd486391872;
   localparam logic [23:0]           JUMP_LIMIT_RESET  = 24'd9830;
   localparam logic [RUN_WIDTH-1:0]  MAX_REJECTS_RESET = 4'd5;
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET      = 16'd9830;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_GAIN      = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JUMP_LIMIT      = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_REJECTS     = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SMOOTHING_ALPHA = 4'd3;

endpackage

>>> rtl/sje_mul.sv
// ----------------------------------------------------------------------------
// sje_mul: shared unsigned multiplier
// One 32x32 unsigned multiply with a registered product.
// ----------------------------------------------------------------------------
module sje_mul (
   input  logic                           clock,
   input  logic [sje_pkg::MUL_WIDTH-1:0]  op_a,
   input  logic [sje_pkg::MUL_WIDTH-1:0]  op_b,
   output logic [sje_pkg::PROD_WIDTH-1:0] product
);

   logic [sje_pkg::PROD_WIDTH-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= sje_pkg::PROD_WIDTH'(op_a) * sje_pkg::PROD_WIDTH'(op_b);
   end

   assign product = product_ff;

endmodule

>>> rtl/sonar_jump_reject_ema.sv
// ----------------------------------------------------------------------------
// sonar_jump_reject_ema: sonar height filter
// Scales echo counts to Q8.16 meters, rejects jumps, smooths with an EMA.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_raw_count, req_restart
//   rsp      out        rsp_valid / rsp_ready  filtered, raw height, reject info
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// Rejected: scale, check, finish. Blended: scale, check, mul-new, mul-old, blend, finish.
// One shared 32x32 multiplier does the scale and both blend products.
// A repeated count is absorbed in the accept cycle and gives no response.
// req_ready is high only while the sequencer is idle; a finished response
// waits in the output register while the next request is taken.
// Reset is synchronous; csr_ready is always high.
// ----------------------------------------------------------------------------
module sonar_jump_reject_ema #(
   parameter int COUNT_WIDTH = sje_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [sje_pkg::COUNT_PORT_WIDTH-1:0]   req_raw_count,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sje_pkg::HEIGHT_WIDTH-1:0]       rsp_filtered_height,
   output logic [sje_pkg::HEIGHT_WIDTH-1:0]       rsp_raw_height,
   output logic                                   rsp_rejected,
   output logic [sje_pkg::RUN_WIDTH-1:0]          rsp_reject_run,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sje_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sje_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int HW = sje_pkg::HEIGHT_WIDTH;
   localparam int AW = sje_pkg::AVG_WIDTH;
   localparam int LW = sje_pkg::ALPHA_WIDTH;
   localparam int RW = sje_pkg::RUN_WIDTH;
   localparam int PW = sje_pkg::PROD_WIDTH;
   localparam int MW = sje_pkg::MUL_WIDTH;
   localparam int TERM_WIDTH = LW + AW;
   localparam int SUM_WIDTH  = TERM_WIDTH + 1;
   localparam int FRAC_SHIFT = AW - HW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_CHECK,
      S_MUL_NEW,
      S_MUL_OLD,
      S_BLEND,
      S_FINISH
   } state_type;

   state_type               state_ff;

   logic [31:0]             count_gain_ff;
   logic [23:0]             jump_limit_ff;
   logic [RW-1:0]           max_rejects_ff;
   logic [LW-1:0]           smoothing_alpha_ff;

   logic [COUNT_WIDTH-1:0]  last_count_ff;
   logic                    last_count_valid_ff;
   logic                    seeded_ff;
   logic [AW-1:0]           average_ff;
   logic [RW-1:0]           reject_counter_ff;

   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [HW-1:0]           raw_height_ff;
   logic [AW-1:0]           sample_ff;
   logic                    rejected_ff;
   logic [TERM_WIDTH-1:0]   acc_ff;

   logic                    rsp_valid_ff;
   logic [HW-1:0]           rsp_filtered_ff;
   logic [HW-1:0]           rsp_raw_ff;
   logic                    rsp_rejected_ff;
   logic [RW-1:0]           rsp_run_ff;

   logic [COUNT_WIDTH-1:0]  req_count;
   logic                    req_fire;
   logic                    req_repeat;
   logic [MW-1:0]           mul_a;
   logic [MW-1:0]           mul_b;
   logic [PW-1:0]           product;
   logic [HW-1:0]           scaled_height;
   logic [AW-1:0]           sample_height;
   logic [AW-1:0]           base_average;
   logic [AW-1:0]           deviation;
   logic                    jump;
   logic [LW-1:0]           alpha;
   logic [SUM_WIDTH-1:0]    blend_sum;
   logic                    rsp_free;

   assign req_count  = req_raw_count[COUNT_WIDTH-1:0];
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign req_repeat = last_count_valid_ff && (req_count == last_count_ff);
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign alpha = (smoothing_alpha_ff > sje_pkg::ALPHA_ONE) ? sje_pkg::ALPHA_ONE
                                                            : smoothing_alpha_ff;

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         S_MUL_NEW: begin
            mul_a = MW'(sample_ff);
            mul_b = MW'(alpha);
         end
         S_MUL_OLD: begin
            mul_a = MW'(average_ff);
            mul_b = MW'(sje_pkg::ALPHA_ONE - alpha);
         end
         default: begin
            mul_a = MW'(count_ff);
            mul_b = count_gain_ff;
         end
      endcase
   end

   sje_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   // scale check: saturate the high word, seed, measure the jump
   assign scaled_height = (product[PW-1:MW+HW] != '0) ? sje_pkg::HEIGHT_MAX
                                                      : product[MW+HW-1:MW];
   assign sample_height = {scaled_height, {FRAC_SHIFT{1'b0}}};
   assign base_average  = seeded_ff ? average_ff : sample_height;
   assign deviation     = (sample_height >= base_average) ? sample_height - base_average
                                                          : base_average - sample_height;
   assign jump = (deviation > {jump_limit_ff, {FRAC_SHIFT{1'b0}}})
                 && (reject_counter_ff < max_rejects_ff);

   assign blend_sum = SUM_WIDTH'(acc_ff) + SUM_WIDTH'(product[TERM_WIDTH-1:0])
                      + SUM_WIDTH'(sje_pkg::ALPHA_ONE >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_IDLE;
         count_gain_ff       <= sje_pkg::COUNT_GAIN_RESET;
         jump_limit_ff       <= sje_pkg::JUMP_LIMIT_RESET;
         max_rejects_ff      <= sje_pkg::MAX_REJECTS_RESET;
         smoothing_alpha_ff  <= sje_pkg::ALPHA_RESET;
         last_count_ff       <= '0;
         last_count_valid_ff <= 1'b0;
         seeded_ff           <= 1'b0;
         average_ff          <= '0;
         reject_counter_ff   <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               sje_pkg::CSR_COUNT_GAIN:      count_gain_ff      <= csr_data;
               sje_pkg::CSR_JUMP_LIMIT:      jump_limit_ff      <= csr_data[23:0];
               sje_pkg::CSR_MAX_REJECTS:     max_rejects_ff     <= csr_data[RW-1:0];
               sje_pkg::CSR_SMOOTHING_ALPHA: smoothing_alpha_ff <= csr_data[LW-1:0];
               default: ;
            endcase
         end

         // the finish step reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_restart) begin
                     seeded_ff <= 1'b0;
                  end
                  // drop a repeated count; only a restart still clears the seeded flag
                  if (!req_repeat) begin
                     last_count_ff       <= req_count;
                     last_count_valid_ff <= 1'b1;
                     count_ff            <= req_count;
                     state_ff            <= S_SCALE;
                  end
               end
            end
            S_SCALE: state_ff <= S_CHECK;
            S_CHECK: begin
               raw_height_ff <= scaled_height;
               sample_ff     <= sample_height;
               average_ff    <= base_average;
               seeded_ff     <= 1'b1;
               rejected_ff   <= jump;
               if (jump) begin
                  reject_counter_ff <= reject_counter_ff + 1'b1;
                  state_ff          <= S_FINISH;
               end else begin
                  reject_counter_ff <= '0;
                  state_ff          <= S_MUL_NEW;
               end
            end
            S_MUL_NEW: state_ff <= S_MUL_OLD;
            S_MUL_OLD: begin
               acc_ff   <= product[TERM_WIDTH-1:0];
               state_ff <= S_BLEND;
            end
            S_BLEND: begin
               average_ff <= blend_sum[sje_pkg::ALPHA_SHIFT +: AW];
               state_ff   <= S_FINISH;
            end
            S_FINISH: begin
               // hold until the output register is free
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_filtered_ff <= average_ff[AW-1:FRAC_SHIFT];
                  rsp_raw_ff      <= raw_height_ff;
                  rsp_rejected_ff <= rejected_ff;
                  rsp_run_ff      <= reject_counter_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_height = rsp_filtered_ff;
   assign rsp_raw_height      = rsp_raw_ff;
   assign rsp_rejected        = rsp_rejected_ff;
   assign rsp_reject_run      = rsp_run_ff;

   a_rejected_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_reject_run != '0))
      else $error("rejected response with empty reject run");

   a_accepted_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_rejected) |-> (rsp_reject_run == '0))
      else $error("accepted response with nonzero reject run");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish step");

   a_repeat_drop: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_repeat) |=> (state_ff == S_IDLE))
      else $error("repeated count started the sequencer");

endmodule
